FILE: rtl/running_mean_variance_top_macros.svh
// ----------------------------------------------------------------------------
// Running mean and variance: assertion macros
// Shared concurrent assertion forms used by the running mean block.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEAN_VARIANCE_TOP_MACROS_SVH
`define RUNNING_MEAN_VARIANCE_TOP_MACROS_SVH

// Condition implies consequence in the same cycle.
`define RMV_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the following cycle.
`define RMV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rmv_pkg.sv
// ----------------------------------------------------------------------------
// Running mean and variance: package
// Widths, status codes, sequencer states and shared types.
// ----------------------------------------------------------------------------
package rmv_pkg;

    // Sample and fixed-point format.
    localparam int SAMPLE_WIDTH = 16;
    localparam int FRAC_BITS    = 16;
    localparam int COUNT_W      = 32;
    localparam int MEAN_W       = 32;
    localparam int ACC_W        = 64;
    localparam int STATUS_W     = 2;

    // Derived datapath widths.
    localparam int SFIX_W  = SAMPLE_WIDTH + FRAC_BITS;
    localparam int DELTA_W = ((SFIX_W > MEAN_W) ? SFIX_W : MEAN_W) + 1;
    localparam int MAG_W   = DELTA_W - 1;
    localparam int NEWM_W  = MAG_W + 2;
    localparam int PROD_W  = 2 * MAG_W;
    localparam int INC_W   = PROD_W - FRAC_BITS;
    localparam int SUMX_W  = ((INC_W > ACC_W) ? INC_W : ACC_W) + 1;
    localparam int STEP_W  = $clog2(MAG_W);

    // Stream payload widths, padded to whole bytes.
    localparam int IN_DATA_W  = ((SAMPLE_WIDTH + COUNT_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((MEAN_W + ACC_W + 7) / 8) * 8;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_MEAN,
        S_BDIFF,
        S_MSTART,
        S_DEV,
        S_OUT
    } t_state;

    // Status returned by the deviation unit.
    typedef struct packed {
        logic done;
        logic sat;
    } t_dev_sts;

endpackage

FILE: rtl/running_mean_variance_top.sv
// ----------------------------------------------------------------------------
// Running mean and variance: top level
// Welford update of a Q16.16 running mean and a Q48.16 deviation sum.
// ----------------------------------------------------------------------------
// Each item (sample, count including this sample) yields one result holding
// the new mean, the new saturating sum of squared deviations and a status.
// An item with a nonzero count passes through the 32-step restoring divider
// that forms delta / count one bit per cycle and then the short multiply and
// accumulate pipeline; its result is then loaded and the next item can be
// accepted. An item with a zero count leaves the state unchanged and returns
// status 2. The input is accepted again while a finished result still waits
// in the output register.
module running_mean_variance_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input item stream.
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [rmv_pkg::IN_DATA_W-1:0]      i_s_tdata,  // sample, sample_count
    // Result item stream.
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [rmv_pkg::OUT_DATA_W-1:0]     o_m_tdata,  // mean_value, deviation_sum
    output logic [rmv_pkg::STATUS_W-1:0]       o_m_tuser   // status
);

`include "running_mean_variance_top_macros.svh"

    rmv_pkg::t_state r_state;
    rmv_pkg::t_state n_state;

    // Statistics state.
    logic signed [rmv_pkg::MEAN_W-1:0]  r_mean;
    logic        [rmv_pkg::ACC_W-1:0]   r_sum;

    // Per-item working registers.
    logic signed [rmv_pkg::SFIX_W-1:0]  r_sfix;
    logic        [rmv_pkg::COUNT_W-1:0] r_count;
    logic signed [rmv_pkg::DELTA_W-1:0] r_delta;
    logic signed [rmv_pkg::MEAN_W-1:0]  r_newm;
    logic signed [rmv_pkg::DELTA_W-1:0] r_bdiff;
    rmv_pkg::t_status                   r_status;

    // Output register.
    logic                               r_out_valid;
    logic        [rmv_pkg::MEAN_W-1:0]  r_out_mean;
    logic        [rmv_pkg::ACC_W-1:0]   r_out_sum;
    rmv_pkg::t_status                   r_out_status;

    // Sequencer outputs.
    logic w_accept;
    logic w_div_start;
    logic w_dev_start;
    logic w_out_load;

    // Input fields and delta.
    logic signed [rmv_pkg::SAMPLE_WIDTH-1:0] w_sample;
    logic        [rmv_pkg::COUNT_W-1:0]      w_count;
    logic signed [rmv_pkg::SFIX_W-1:0]       w_sfix;
    logic signed [rmv_pkg::DELTA_W-1:0]      w_delta;

    // Divider interface.
    logic [rmv_pkg::DELTA_W-1:0] w_neg_delta;
    logic [rmv_pkg::MAG_W-1:0]   w_dmag;
    logic                        w_div_done;
    logic [rmv_pkg::MAG_W-1:0]   w_quo;

    // Mean update.
    logic signed [rmv_pkg::NEWM_W-1:0] w_mx;
    logic signed [rmv_pkg::NEWM_W-1:0] w_qx;
    logic signed [rmv_pkg::NEWM_W-1:0] w_newm;
    logic                              w_newm_ovf;
    logic signed [rmv_pkg::MEAN_W-1:0] w_newm_sat;

    // Deviation unit interface.
    rmv_pkg::t_dev_sts           w_dev_sts;
    logic [rmv_pkg::ACC_W-1:0]   w_dev_sum;

    // Unpack the input item and form sample minus mean.
    assign w_sample = i_s_tdata[rmv_pkg::SAMPLE_WIDTH-1:0];
    assign w_count  = i_s_tdata[rmv_pkg::SAMPLE_WIDTH +: rmv_pkg::COUNT_W];
    assign w_sfix   = {w_sample, {rmv_pkg::FRAC_BITS{1'b0}}};
    assign w_delta  = rmv_pkg::DELTA_W'(w_sfix) - rmv_pkg::DELTA_W'(r_mean);
    assign w_accept = i_s_tvalid && o_s_tready;

    // Divider takes the magnitude of delta; the sign is restored afterwards.
    assign w_neg_delta = -r_delta;
    assign w_dmag      = r_delta[rmv_pkg::DELTA_W-1] ? w_neg_delta[rmv_pkg::MAG_W-1:0]
                                                     : r_delta[rmv_pkg::MAG_W-1:0];

    rmv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dmag),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // New mean, truncated toward zero, clamped to the signed mean range.
    assign w_mx       = rmv_pkg::NEWM_W'(r_mean);
    assign w_qx       = rmv_pkg::NEWM_W'(w_quo);
    assign w_newm     = r_delta[rmv_pkg::DELTA_W-1] ? (w_mx - w_qx) : (w_mx + w_qx);
    assign w_newm_ovf = !((&w_newm[rmv_pkg::NEWM_W-1:rmv_pkg::MEAN_W-1]) ||
                          (~|w_newm[rmv_pkg::NEWM_W-1:rmv_pkg::MEAN_W-1]));
    assign w_newm_sat = !w_newm_ovf ? w_newm[rmv_pkg::MEAN_W-1:0] :
                        w_newm[rmv_pkg::NEWM_W-1] ? {1'b1, {(rmv_pkg::MEAN_W-1){1'b0}}}
                                                  : {1'b0, {(rmv_pkg::MEAN_W-1){1'b1}}};

    rmv_dev u_dev (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dev_start),
        .i_delta (r_delta),
        .i_bdiff (r_bdiff),
        .i_sum   (r_sum),
        .o_sts   (w_dev_sts),
        .o_sum   (w_dev_sum)
    );

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rmv_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state and strobes.
    always_comb begin
        n_state     = r_state;
        o_s_tready  = 1'b0;
        w_div_start = 1'b0;
        w_dev_start = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            rmv_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_state = (w_count == '0) ? rmv_pkg::S_OUT : rmv_pkg::S_LOAD;
                end
            end
            rmv_pkg::S_LOAD: begin
                w_div_start = 1'b1;
                n_state     = rmv_pkg::S_DIV;
            end
            rmv_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = rmv_pkg::S_MEAN;
                end
            end
            rmv_pkg::S_MEAN: begin
                n_state = rmv_pkg::S_BDIFF;
            end
            rmv_pkg::S_BDIFF: begin
                n_state = rmv_pkg::S_MSTART;
            end
            rmv_pkg::S_MSTART: begin
                w_dev_start = 1'b1;
                n_state     = rmv_pkg::S_DEV;
            end
            rmv_pkg::S_DEV: begin
                if (w_dev_sts.done) begin
                    n_state = rmv_pkg::S_OUT;
                end
            end
            rmv_pkg::S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    w_out_load = 1'b1;
                    n_state    = rmv_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rmv_pkg::S_IDLE;
            end
        endcase
    end

    // Statistics state: updated once the deviation unit finishes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= '0;
            r_sum  <= '0;
        end else if ((r_state == rmv_pkg::S_DEV) && w_dev_sts.done) begin
            r_mean <= r_newm;
            r_sum  <= w_dev_sum;
        end
    end

    // Per-item working registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sfix   <= w_sfix;
            r_count  <= w_count;
            r_delta  <= w_delta;
            r_status <= rmv_pkg::ST_ZERO;
        end
        if (r_state == rmv_pkg::S_MEAN) begin
            r_newm <= w_newm_sat;
        end
        if (r_state == rmv_pkg::S_BDIFF) begin
            r_bdiff <= rmv_pkg::DELTA_W'(r_sfix) - rmv_pkg::DELTA_W'(r_newm);
        end
        if ((r_state == rmv_pkg::S_DEV) && w_dev_sts.done) begin
            r_status <= w_dev_sts.sat ? rmv_pkg::ST_SAT : rmv_pkg::ST_OK;
        end
    end

    // Output register: holds a result until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_mean   <= r_mean;
            r_out_sum    <= r_sum;
            r_out_status <= r_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = rmv_pkg::OUT_DATA_W'({r_out_sum, r_out_mean});
    assign o_m_tuser  = r_out_status;

    // A result loaded into the output register is presented next cycle.
    `RMV_ASSERT_NEXT(a_out_load_valid, i_clk, i_rst_n, w_out_load, o_m_tvalid, "output load lost")

    // A saturated status always comes with an all-ones deviation sum.
    `RMV_ASSERT_SAME(a_sat_all_ones, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == rmv_pkg::ST_SAT), o_m_tdata[rmv_pkg::MEAN_W +: rmv_pkg::ACC_W] == '1, "saturated sum not all ones")

    // The divider only finishes while the sequencer waits for it.
    `RMV_ASSERT_SAME(a_div_done_state, i_clk, i_rst_n, w_div_done, r_state == rmv_pkg::S_DIV, "divider done outside divide state")

    // An accepted item always takes the block out of its ready state.
    `RMV_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, !o_s_tready, "ready held after accept")

endmodule

FILE: rtl/rmv_div.sv
// ----------------------------------------------------------------------------
// Running mean and variance: iterative divider
// Unsigned restoring divider, one quotient bit per cycle on one subtractor.
// ----------------------------------------------------------------------------
module rmv_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rmv_pkg::MAG_W-1:0]   i_dividend,
    input  logic [rmv_pkg::COUNT_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [rmv_pkg::MAG_W-1:0]   o_quotient
);

    logic                        r_busy;
    logic                        r_done;
    logic [rmv_pkg::STEP_W-1:0]  r_step;
    logic [rmv_pkg::COUNT_W-1:0] r_rem;
    logic [rmv_pkg::MAG_W-1:0]   r_quo;
    logic [rmv_pkg::COUNT_W-1:0] r_div;

    logic [rmv_pkg::COUNT_W:0]   w_shift;
    logic [rmv_pkg::COUNT_W+1:0] w_diff;
    logic                        w_fit;

    // Shift in the next dividend bit and trial-subtract the divisor.
    assign w_shift = {r_rem, r_quo[rmv_pkg::MAG_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_div};
    assign w_fit   = ~w_diff[rmv_pkg::COUNT_W+1];

    // Control: busy for one pass over all dividend bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == rmv_pkg::STEP_W'(rmv_pkg::MAG_W - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: remainder, quotient and step count.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= '0;
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            r_rem  <= w_fit ? w_diff[rmv_pkg::COUNT_W-1:0] : w_shift[rmv_pkg::COUNT_W-1:0];
            r_quo  <= {r_quo[rmv_pkg::MAG_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/rmv_dev.sv
// ----------------------------------------------------------------------------
// Running mean and variance: deviation accumulator
// Magnitudes, one registered multiply, then the saturating sum update.
// ----------------------------------------------------------------------------
module rmv_dev (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [rmv_pkg::DELTA_W-1:0] i_delta,
    input  logic signed [rmv_pkg::DELTA_W-1:0] i_bdiff,
    input  logic        [rmv_pkg::ACC_W-1:0]   i_sum,
    output rmv_pkg::t_dev_sts                  o_sts,
    output logic        [rmv_pkg::ACC_W-1:0]   o_sum
);

    logic                         r_v0;
    logic                         r_v1;
    logic                         r_v2;
    logic [rmv_pkg::MAG_W-1:0]    r_mag_d;
    logic [rmv_pkg::MAG_W-1:0]    r_mag_b;
    logic                         r_pos;
    logic [rmv_pkg::PROD_W-1:0]   r_prod;
    logic [rmv_pkg::ACC_W-1:0]    r_sum;
    logic                         r_sat;

    logic [rmv_pkg::DELTA_W-1:0]  w_neg_d;
    logic [rmv_pkg::DELTA_W-1:0]  w_neg_b;
    logic [rmv_pkg::MAG_W-1:0]    w_mag_d;
    logic [rmv_pkg::MAG_W-1:0]    w_mag_b;
    logic                         w_pos;
    logic [rmv_pkg::PROD_W-1:0]   w_prod;
    logic [rmv_pkg::INC_W-1:0]    w_inc;
    logic [rmv_pkg::SUMX_W-1:0]   w_sumx;
    logic                         w_sat;

    // Magnitudes; the product counts only when both factors share a sign.
    assign w_neg_d = -i_delta;
    assign w_neg_b = -i_bdiff;
    assign w_mag_d = i_delta[rmv_pkg::DELTA_W-1] ? w_neg_d[rmv_pkg::MAG_W-1:0]
                                                 : i_delta[rmv_pkg::MAG_W-1:0];
    assign w_mag_b = i_bdiff[rmv_pkg::DELTA_W-1] ? w_neg_b[rmv_pkg::MAG_W-1:0]
                                                 : i_bdiff[rmv_pkg::MAG_W-1:0];
    assign w_pos   = (i_delta != '0) && (i_bdiff != '0) &&
                     (i_delta[rmv_pkg::DELTA_W-1] == i_bdiff[rmv_pkg::DELTA_W-1]);

    // Exact product of the magnitudes.
    assign w_prod = rmv_pkg::PROD_W'(r_mag_d) * rmv_pkg::PROD_W'(r_mag_b);

    // Drop the fraction bits and add with saturation at all ones.
    assign w_inc  = r_prod[rmv_pkg::PROD_W-1:rmv_pkg::FRAC_BITS];
    assign w_sumx = rmv_pkg::SUMX_W'(i_sum) + rmv_pkg::SUMX_W'(w_inc);
    assign w_sat  = |w_sumx[rmv_pkg::SUMX_W-1:rmv_pkg::ACC_W];

    // Stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_start;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag_d <= w_mag_d;
            r_mag_b <= w_mag_b;
            r_pos   <= w_pos;
        end
        if (r_v0) begin
            r_prod <= r_pos ? w_prod : '0;
        end
        if (r_v1) begin
            r_sum <= w_sat ? '1 : w_sumx[rmv_pkg::ACC_W-1:0];
            r_sat <= w_sat;
        end
    end

    assign o_sts.done = r_v2;
    assign o_sts.sat  = r_sat;
    assign o_sum      = r_sum;

endmodule

FILE: tb/tb_running_mean_variance_top.sv
// ----------------------------------------------------------------------------
// Running mean and variance: self-checking testbench
// Drives sample/count items into the Welford update block and compares each
// result item against an internal fixed-point model of the update.
// ----------------------------------------------------------------------------
// A short directed table covers zero counts, sample and count extremes and
// the largest single-item increment. Random streams follow. Most of them are
// runs of rising counts, as a real profiler would send, mixed with zero
// counts and arbitrary counts. The streams go through phases with no
// back-pressure, sender gaps, receiver stalls and both at once. One phase
// holds the receiver off long enough for the block to stall its input.
module tb_running_mean_variance_top;

    localparam int     CYCLE_LIMIT  = 1_000_000;
    localparam int     DRAIN_CYCLES = 60;
    localparam int     HOLD_CYCLES  = 400;
    localparam longint MEAN_MAX     = 64'sd2147483647;
    localparam longint MEAN_MIN     = -64'sd2147483648;

    // One result item: mean, deviation sum and status.
    typedef struct packed {
        logic [rmv_pkg::MEAN_W-1:0] mean;
        logic [rmv_pkg::ACC_W-1:0]  sum;
        rmv_pkg::t_status           status;
    } t_stat;

    // One directed row; the result is typed in only where known is set.
    typedef struct packed {
        logic [rmv_pkg::SAMPLE_WIDTH-1:0] smp;
        logic [rmv_pkg::COUNT_W-1:0]      cnt;
        logic                             known;
        logic [rmv_pkg::MEAN_W-1:0]       mean;
        logic [rmv_pkg::ACC_W-1:0]        sum;
        rmv_pkg::t_status                 status;
    } t_dir_row;

    // Back-pressure phases.
    typedef enum int {
        PH_FREE,
        PH_TX_IDLE,
        PH_RX_STALL,
        PH_BOTH,
        PH_PRESSURE
    } t_phase;

    localparam int DIR_ROWS = 20;
    localparam t_dir_row DIRECTED_ROWS [DIR_ROWS] = '{
        '{16'h0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 64'h0, rmv_pkg::ST_ZERO},
        '{16'h8000, 32'h0000_0001, 1'b1, 32'h8000_0000, 64'h0, rmv_pkg::ST_OK},
        '{16'h0000, 32'h0000_0000, 1'b1, 32'h8000_0000, 64'h0, rmv_pkg::ST_ZERO},
        '{16'h7FFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 64'h0, rmv_pkg::ST_OK},
        '{16'h7FFF, 32'h0000_0001, 1'b0, 32'h0, 64'h0, rmv_pkg::ST_OK},
        '{16'h8000, 32'h0000_0002, 1'b0, 32'h0, 64'h0, rmv_pkg::ST_OK},
        '{16'h0000, 32'h0000_0000, 1'b0, 32'h0, 64'h0, rmv_pkg::ST_OK},
        '{16'h5555, 32'h0000_0003, 1'b0, 32'h0, 64'h0, rmv_pkg::ST_OK},
        '{16'hAAAA, 32'h0000_0004, 1'b0, 32'h0, 64'h0, rmv_pkg::ST_OK},
        '{16'h0000, 32'h8000_0000, 1'b0, 32'h0, 64'h0, rmv_pkg::ST_OK},
        '{16'hFFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 64'h0, rmv_pkg::ST_OK},
        '{16'h0001, 32'h7FFF_FFFF, 1'b0, 32'h0, 64'h0, rmv_pkg::ST_OK},
        '{16'h00FF, 32'h0000_FFFF, 1'b0, 32'h0, 64'h0, rmv_pkg::ST_OK},
        '{16'hFF00, 32'hFFFF_0000, 1'b0, 32'h0, 64'h0, rmv_pkg::ST_OK},
        '{16'h1234, 32'h0000_0005, 1'b0, 32'h0, 64'h0, rmv_pkg::ST_OK},
        '{16'hEDCC, 32'h0000_0006, 1'b0, 32'h0, 64'h0, rmv_pkg::ST_OK},
        '{16'h7FFF, 32'h0000_0007, 1'b0, 32'h0, 64'h0, rmv_pkg::ST_OK},
        '{16'h8000, 32'h0000_0008, 1'b0, 32'h0, 64'h0, rmv_pkg::ST_OK},
        '{16'h0000, 32'h0000_0001, 1'b0, 32'h0, 64'h0, rmv_pkg::ST_OK},
        '{16'h3039, 32'h0000_0002, 1'b0, 32'h0, 64'h0, rmv_pkg::ST_OK}
    };

    // DUT connections.
    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [rmv_pkg::IN_DATA_W-1:0]  i_s_tdata  = '0;  // sample, sample_count
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic [rmv_pkg::OUT_DATA_W-1:0] o_m_tdata;        // mean_value, deviation_sum
    logic [rmv_pkg::STATUS_W-1:0]   o_m_tuser;        // status

    // Model state and bookkeeping.
    logic signed [rmv_pkg::MEAN_W-1:0] run_mean = '0;
    logic [rmv_pkg::ACC_W-1:0]         dev_sum  = '0;
    t_stat                             expected_stats[$];
    t_stat                             oldest_stats;
    int                                mismatches   = 0;
    int                                cycle_count  = 0;
    int                                tx_idle_pct  = 0;
    int                                rx_stall_pct = 0;
    int                                rx_hold_left = 0;
    int                                seq_left     = 0;
    logic [rmv_pkg::COUNT_W-1:0]       seq_count    = '0;

    running_mean_variance_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Clock.
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Cycle counter and run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_stats.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        $display("Mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Welford update in fixed point: advances the running mean and the
    // saturating deviation sum, and returns the result item the block owes.
    function automatic t_stat welford_update(
        input logic signed [rmv_pkg::SAMPLE_WIDTH-1:0] smp,
        input logic [rmv_pkg::COUNT_W-1:0] cnt);
        t_stat        res;
        longint       sfix;
        longint       m;
        longint       delta;
        longint       newm;
        longint       b;
        logic [63:0]  mag_d;
        logic [63:0]  mag_b;
        logic [127:0] prod;
        logic [63:0]  inc;
        logic [64:0]  acc;
        res.status = rmv_pkg::ST_OK;
        // A zero count leaves the state alone and reports it.
        if (cnt == '0) begin
            res.mean   = run_mean;
            res.sum    = dev_sum;
            res.status = rmv_pkg::ST_ZERO;
            return res;
        end
        sfix  = longint'(smp) <<< rmv_pkg::FRAC_BITS;
        m     = longint'(run_mean);
        delta = sfix - m;
        newm  = m + delta / longint'({32'd0, cnt});
        if (newm > MEAN_MAX) newm = MEAN_MAX;
        if (newm < MEAN_MIN) newm = MEAN_MIN;
        b = sfix - newm;
        // Only a positive product adds to the sum; a negative one adds zero.
        inc = '0;
        if (delta != 0 && b != 0 && ((delta < 0) == (b < 0))) begin
            mag_d = (delta < 0) ? 64'(-delta) : 64'(delta);
            mag_b = (b < 0) ? 64'(-b) : 64'(b);
            prod  = ({64'd0, mag_d} * {64'd0, mag_b}) >> rmv_pkg::FRAC_BITS;
            if (prod[127:64] != '0) begin
                inc        = '1;
                res.status = rmv_pkg::ST_SAT;
            end else begin
                inc = prod[63:0];
            end
        end
        // Saturating accumulate.
        acc = {1'b0, dev_sum} + {1'b0, inc};
        if (acc[64]) begin
            acc[63:0]  = '1;
            res.status = rmv_pkg::ST_SAT;
        end
        run_mean = rmv_pkg::MEAN_W'(newm);
        dev_sum  = acc[63:0];
        res.mean = run_mean;
        res.sum  = dev_sum;
        return res;
    endfunction

    // Offers one item, waits for its handshake and queues its expected result.
    task automatic offer_item(input logic [rmv_pkg::SAMPLE_WIDTH-1:0] smp,
                              input logic [rmv_pkg::COUNT_W-1:0] cnt,
                              input logic known, input t_stat known_stats);
        t_stat pred;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= rmv_pkg::IN_DATA_W'({cnt, smp});
        do @(posedge i_clk); while (!o_s_tready);
        pred = welford_update(smp, cnt);
        expected_stats.push_back(known ? known_stats : pred);
    endtask

    task automatic set_phase(input t_phase ph);
        case (ph)
            PH_FREE:     begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            PH_TX_IDLE:  begin tx_idle_pct = 52; rx_stall_pct = 0;  end
            PH_RX_STALL: begin tx_idle_pct = 0;  rx_stall_pct = 52; end
            PH_BOTH:     begin tx_idle_pct = 12; rx_stall_pct = 12; end
            PH_PRESSURE: begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
                rx_hold_left = HOLD_CYCLES;
            end
            default:     begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        endcase
    endtask

    // Random stream: mostly runs of rising counts with random samples, plus
    // zero counts, small counts and arbitrary counts. Zero-count items do not
    // count toward the target since the block leaves its state unchanged for them.
    task automatic random_stream(input int target);
        int                               counted;
        int                               sel;
        logic [rmv_pkg::SAMPLE_WIDTH-1:0] smp;
        logic [rmv_pkg::COUNT_W-1:0]      cnt;
        counted = 0;
        while (counted < target) begin
            sel = $urandom_range(99);
            if (sel < 8) begin
                smp = 16'h8000;
            end else if (sel < 16) begin
                smp = 16'h7FFF;
            end else if (sel < 24) begin
                smp = 16'($urandom_range(8)) - 16'd4;
            end else begin
                smp = 16'($urandom);
            end
            if (seq_left > 0) begin
                seq_left--;
                seq_count = seq_count + 1;
                cnt       = seq_count;
            end else begin
                sel = $urandom_range(99);
                if (sel < 60) begin
                    seq_count = (sel < 50) ? 32'd1 : 32'($urandom);
                    seq_left  = $urandom_range(40, 1) - 1;
                    cnt       = seq_count;
                end else if (sel < 75) begin
                    cnt = '0;
                end else if (sel < 85) begin
                    cnt = 32'($urandom_range(16, 1));
                end else begin
                    cnt = 32'($urandom);
                end
            end
            offer_item(smp, cnt, 1'b0, '0);
            if (cnt != '0) counted++;
        end
    endtask

    // Receiver: random stalls, and a long hold-off counted down here.
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_stats.size() == 0) begin
                report_mismatch($sformatf("unexpected result mean=%h sum=%h status=%0d",
                                          o_m_tdata[rmv_pkg::MEAN_W-1:0],
                                          o_m_tdata[rmv_pkg::MEAN_W +: rmv_pkg::ACC_W],
                                          o_m_tuser));
            end else begin
                oldest_stats = expected_stats.pop_front();
                if (o_m_tdata[rmv_pkg::MEAN_W-1:0] !== oldest_stats.mean) begin
                    report_mismatch($sformatf("mean_value got %h want %h",
                                              o_m_tdata[rmv_pkg::MEAN_W-1:0],
                                              oldest_stats.mean));
                end
                if (o_m_tdata[rmv_pkg::MEAN_W +: rmv_pkg::ACC_W] !== oldest_stats.sum) begin
                    report_mismatch($sformatf("deviation_sum got %h want %h",
                                              o_m_tdata[rmv_pkg::MEAN_W +: rmv_pkg::ACC_W],
                                              oldest_stats.sum));
                end
                if (o_m_tuser !== oldest_stats.status) begin
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_m_tuser, oldest_stats.status));
                end
            end
        end
    end

    // Main sequence.
    initial begin
        t_stat row_stats;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        set_phase(PH_FREE);
        for (int i = 0; i < DIR_ROWS; i++) begin
            row_stats.mean   = DIRECTED_ROWS[i].mean;
            row_stats.sum    = DIRECTED_ROWS[i].sum;
            row_stats.status = DIRECTED_ROWS[i].status;
            offer_item(DIRECTED_ROWS[i].smp, DIRECTED_ROWS[i].cnt,
                       DIRECTED_ROWS[i].known, row_stats);
        end

        // Random streams under each kind of back-pressure.
        set_phase(PH_FREE);
        random_stream(260);
        set_phase(PH_TX_IDLE);
        random_stream(260);
        set_phase(PH_RX_STALL);
        random_stream(260);
        set_phase(PH_PRESSURE);
        random_stream(40);
        set_phase(PH_BOTH);
        random_stream(230);

        // Drain and settle.
        i_s_tvalid <= 1'b0;
        while (expected_stats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
